// ===== hdl/srg_pkg.sv =====
// Shared types and constants for the shade ramp generator.
// Used by srg_front, srg_queue, srg_back and shade_ramp_generator_unit; no dependencies.
package srg_pkg;

   localparam int QueueDepth = 2;

   localparam logic [5:0] RampMid  = 6'd32;
   localparam logic [5:0] RampLast = 6'd63;

   // floor(n/31) == (n * RecipK) >> RecipShift for every n below 34952
   localparam logic [15:0] RecipK     = 16'd33826;
   localparam int          RecipShift = 20;

   localparam logic [5:0] ChanMax5 = 6'd31;
   localparam logic [5:0] ChanMax6 = 6'd63;

   // one colour cut to pixel precision, with the format it was cut for
   typedef struct packed {
      logic       fmt565;
      logic [4:0] red;
      logic [5:0] green;
      logic [4:0] blue;
   } chan_type;

endpackage

// ===== hdl/shade_ramp_generator_unit.sv =====
// Shade ramp generator: one 24-bit colour in, 64 packed 5/6/5 or 5/5/5 pixels out.
// The first word of a ramp passes the queue, the stage-1 register and the output register.
// Throughput: one word per cycle while rsp_tready holds; the entry counter gives 64 words per colour.
// Reset (synchronous, active high) empties the queue, clears the pipeline and
// selects 5/5/5 pixels.
// Depends on srg_pkg, srg_front, srg_queue and srg_back.
module shade_ramp_generator_unit #(
   parameter int QUEUE_DEPTH = srg_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   // format register: 1 selects 5/6/5, 0 selects 5/5/5
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   // colour words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] rgb_color
   // ramp words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [5:0] entry_index, [21:6] packed_pixel, [23:22] zero
   output logic        rsp_tlast    // last_entry
);

   srg_pkg::chan_type push_data;
   srg_pkg::chan_type head_data;
   logic              push_valid;
   logic              push_ready;
   logic              head_valid;
   logic              head_pop;

   // front: latch the format, cut each colour to channel levels
   srg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   // hold waiting colours so the front keeps accepting while a ramp drains
   srg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (head_valid),
      .pop_ready  (head_pop),
      .pop_data   (head_data)
   );

   // back: advance through entries 0..63, drop the head colour after entry 63
   srg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head_data  (head_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hdl/srg_front.sv =====
// Front end: holds the format register, accepts colours and cuts them to channel levels.
// Depends on srg_pkg.
module srg_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,
   output logic              push_valid,
   input  logic              push_ready,
   output srg_pkg::chan_type push_data
);

   logic fmt565_ff;
   logic fmt565_in;

   assign fmt565_in = csr_wr_en ? csr_wr_data : fmt565_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt565_ff <= 1'b0;
      end else begin
         fmt565_ff <= fmt565_in;
      end
   end

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

   always_comb begin
      push_data.fmt565 = fmt565_ff;
      push_data.red    = req_tdata[23:19];
      push_data.green  = fmt565_ff ? req_tdata[15:10] : {1'b0, req_tdata[15:11]};
      push_data.blue   = req_tdata[7:3];
   end

endmodule

// ===== hdl/srg_queue.sv =====
// Short queue of classified colours between the front end and the ramp sequencer.
// Depends on srg_pkg.
module srg_queue #(
   parameter int DEPTH = srg_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  srg_pkg::chan_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output srg_pkg::chan_type pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   srg_pkg::chan_type store_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/srg_back.sv =====
// Back end: steps through the 64 ramp entries of the head colour in a two-stage pipeline.
// Depends on srg_pkg.
module srg_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   output logic              head_pop,
   input  srg_pkg::chan_type head_data,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,
   output logic              rsp_tlast
);

   typedef struct packed {
      logic [5:0]  idx;
      logic        fmt565;
      logic        dark;
      logic [10:0] sum_r;
      logic [10:0] sum_g;
      logic [10:0] sum_b;
   } stage_type;

   // dark half: c*e; light half: 31c + j(m-c) + 15, so that a floor by 31 rounds
   function automatic logic [10:0] ramp_sum(input logic [5:0] c, input logic [5:0] m,
                                            input logic [5:0] e);
      logic [5:0]  d;
      logic [11:0] dk;
      logic [11:0] lt;
      d  = m - c;
      dk = 12'(c) * 12'(e);
      lt = 12'(c) * 12'd31 + 12'(e[4:0]) * 12'(d) + 12'd15;
      return (e <= srg_pkg::RampMid) ? dk[10:0] : lt[10:0];
   endfunction

   function automatic logic [5:0] ramp_level(input logic [10:0] n, input logic dark);
      logic [5:0]  q;
      logic [4:0]  r;
      logic        inc;
      logic [26:0] prod;
      q    = n[10:5];
      r    = n[4:0];
      inc  = (r > 5'd16) || ((r == 5'd16) && q[0]);
      prod = 27'(n) * 27'(srg_pkg::RecipK);
      return dark ? (q + 6'(inc)) : prod[srg_pkg::RecipShift+5:srg_pkg::RecipShift];
   endfunction

   logic [5:0]  cnt_ff, cnt_in;
   logic        s1_valid_ff;
   stage_type   s1_ff, s1_in;
   logic        out_valid_ff;
   logic [5:0]  out_idx_ff;
   logic [15:0] out_pix_ff, out_pix_in;
   logic        advance;
   logic        issue;
   logic [5:0]  gmax;
   logic [5:0]  lvl_r, lvl_g, lvl_b;

   assign advance  = !out_valid_ff || rsp_tready;
   assign issue    = head_valid && advance;
   assign head_pop = issue && (cnt_ff == srg_pkg::RampLast);
   assign cnt_in   = issue ? cnt_ff + 1'b1 : cnt_ff;
   assign gmax     = head_data.fmt565 ? srg_pkg::ChanMax6 : srg_pkg::ChanMax5;

   always_comb begin
      s1_in.idx    = cnt_ff;
      s1_in.fmt565 = head_data.fmt565;
      s1_in.dark   = (cnt_ff <= srg_pkg::RampMid);
      s1_in.sum_r  = ramp_sum({1'b0, head_data.red}, srg_pkg::ChanMax5, cnt_ff);
      s1_in.sum_g  = ramp_sum(head_data.green, gmax, cnt_ff);
      s1_in.sum_b  = ramp_sum({1'b0, head_data.blue}, srg_pkg::ChanMax5, cnt_ff);
   end

   always_comb begin
      lvl_r = ramp_level(s1_ff.sum_r, s1_ff.dark);
      lvl_g = ramp_level(s1_ff.sum_g, s1_ff.dark);
      lvl_b = ramp_level(s1_ff.sum_b, s1_ff.dark);
      if (s1_ff.fmt565) begin
         out_pix_in = {lvl_r[4:0], lvl_g, lvl_b[4:0]};
      end else begin
         out_pix_in = {1'b0, lvl_r[4:0], lvl_g[4:0], lvl_b[4:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (advance) begin
            s1_valid_ff  <= issue;
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff      <= s1_in;
         out_idx_ff <= s1_ff.idx;
         out_pix_ff <= out_pix_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_pix_ff, out_idx_ff};
   assign rsp_tlast  = (out_idx_ff == srg_pkg::RampLast);

endmodule
